/* rtl/vcwr_pkg.sv */
// types, constants and codes shared by the waiter release core
package vcwr_pkg;

  localparam int WAITER_SLOTS = 32;
  localparam int PADDR_W = 4;

  localparam logic REQ_WAIT  = 1'b0;
  localparam logic REQ_BCAST = 1'b1;

  localparam logic [1:0] KIND_NOTIFY = 2'd0;
  localparam logic [1:0] KIND_QUEUED = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [63:0] client_id;
    logic [63:0] request_nonce;
    logic [63:0] target_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] notify_client;
    logic [63:0] notify_nonce;
    logic [63:0] counter_value;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] target;
    logic [63:0] client;
    logic [63:0] nonce;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   place;
    entry_t entry;
  } cell_link_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } pool_ctrl_t;

  typedef struct packed {
    logic   head_valid;
    logic   full;
    entry_t head;
  } pool_status_t;

endpackage

/* rtl/versioned_condition_waiter_release_core.sv */
// top level: event counter, request buffer, release sequencer and result register
//
//   channel  signals                               direction  payload
//   req      req_valid, req_stall, req             in         vcwr_pkg::req_t
//   rsp      rsp_valid, rsp_stall, rsp             out        vcwr_pkg::rsp_t
//   cfg      psel, penable, pwrite, paddr, pwdata  in         initial_count at 0
//
// a wait item passes the request buffer, then its result goes to the result register
// a broadcast bumps the counter, then gives one result per cycle unless rsp stalls
// inserts into the sorted cell chain and releases from its head act on all cells at once
// after reset the pool is empty and the counter is zero
// a stalled rsp holds the sequencer; req is taken into a one-item buffer meanwhile
module versioned_condition_waiter_release_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  vcwr_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output vcwr_pkg::rsp_t               rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vcwr_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  typedef enum logic {IDLE, RELEASE} state_t;

  state_t                 state;
  logic                   req_full;
  vcwr_pkg::req_t         req_q;
  logic [63:0]            initial_count;
  logic [63:0]            counter;
  logic                   out_free;
  logic                   rsp_load;
  logic                   reached;
  logic                   hit;
  logic                   cfg_write;
  vcwr_pkg::pool_ctrl_t   ctrl;
  vcwr_pkg::pool_status_t status;
  vcwr_pkg::entry_t       new_entry;

  assign pready    = 1'b1;
  assign prdata    = initial_count;
  assign cfg_write = psel && penable && pwrite && !paddr[3];

  assign req_stall = req_full;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign reached   = req_q.target_count <= counter;
  assign hit       = status.head_valid && (status.head.target <= counter);

  assign rsp_load = ((state == IDLE) && req_full && out_free &&
                     (req_q.req_type == vcwr_pkg::REQ_WAIT)) ||
                    ((state == RELEASE) && out_free);

  assign new_entry.target = req_q.target_count;
  assign new_entry.client = req_q.client_id;
  assign new_entry.nonce  = req_q.request_nonce;

  assign ctrl.insert = (state == IDLE) && req_full && out_free &&
                       (req_q.req_type == vcwr_pkg::REQ_WAIT) && !reached && !status.full;
  assign ctrl.shift  = (state == RELEASE) && out_free && hit;

  vcwr_pool u_pool (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .new_entry (new_entry),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      req_full      <= 1'b0;
      rsp_valid     <= 1'b0;
      initial_count <= '0;
      counter       <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (req_valid && !req_full) begin
        req_q    <= req;
        req_full <= 1'b1;
      end
      if (cfg_write) begin
        initial_count <= pwdata;
        counter       <= pwdata;
      end
      unique case (state)
        IDLE: begin
          if (req_full && out_free) begin
            req_full <= 1'b0;
            if (req_q.req_type == vcwr_pkg::REQ_WAIT) begin
              rsp.counter_value <= counter;
              rsp.last          <= 1'b1;
              if (reached) begin
                rsp.kind          <= vcwr_pkg::KIND_NOTIFY;
                rsp.notify_client <= req_q.client_id;
                rsp.notify_nonce  <= req_q.request_nonce;
              end else begin
                rsp.kind          <= status.full ? vcwr_pkg::KIND_REJECT
                                                 : vcwr_pkg::KIND_QUEUED;
                rsp.notify_client <= '0;
                rsp.notify_nonce  <= '0;
              end
            end else begin
              counter <= counter + 64'd1;
              state   <= RELEASE;
            end
          end
        end
        RELEASE: begin
          if (out_free) begin
            rsp.counter_value <= counter;
            if (hit) begin
              rsp.kind          <= vcwr_pkg::KIND_NOTIFY;
              rsp.notify_client <= status.head.client;
              rsp.notify_nonce  <= status.head.nonce;
              rsp.last          <= 1'b0;
            end else begin
              rsp.kind          <= vcwr_pkg::KIND_DONE;
              rsp.notify_client <= '0;
              rsp.notify_nonce  <= '0;
              rsp.last          <= 1'b1;
              state             <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/vcwr_cell.sv */
// one waiter cell of the sorted chain: holds one entry, inserts or shifts toward the head
module vcwr_cell (
  input  logic                clk,
  input  logic                rst,
  input  vcwr_pkg::pool_ctrl_t ctrl,
  input  vcwr_pkg::entry_t    new_entry,
  input  vcwr_pkg::cell_link_t left,
  input  vcwr_pkg::cell_link_t right,
  output vcwr_pkg::cell_link_t link
);

  logic             valid;
  vcwr_pkg::entry_t entry;
  logic             place;

  // new entry goes ahead of this one: ties stay behind older entries
  assign place = !valid || (entry.target > new_entry.target);

  assign link.valid = valid;
  assign link.place = place;
  assign link.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && place) begin
      if (!left.place) begin
        valid <= 1'b1;
        entry <= new_entry;
      end else begin
        valid <= left.valid;
        entry <= left.entry;
      end
    end else if (ctrl.shift) begin
      valid <= right.valid;
      entry <= right.entry;
    end
  end

endmodule

/* rtl/vcwr_pool.sv */
// chain of waiter cells kept in ascending target order, head at cell zero
module vcwr_pool (
  input  logic                  clk,
  input  logic                  rst,
  input  vcwr_pkg::pool_ctrl_t  ctrl,
  input  vcwr_pkg::entry_t      new_entry,
  output vcwr_pkg::pool_status_t status
);

  vcwr_pkg::cell_link_t links [vcwr_pkg::WAITER_SLOTS];

  for (genvar i = 0; i < vcwr_pkg::WAITER_SLOTS; i++) begin : g_cell
    vcwr_pkg::cell_link_t left;
    vcwr_pkg::cell_link_t right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_left
      assign left = links[i-1];
    end

    if (i == vcwr_pkg::WAITER_SLOTS - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_right
      assign right = links[i+1];
    end

    vcwr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .left      (left),
      .right     (right),
      .link      (links[i])
    );
  end

  assign status.head_valid = links[0].valid;
  assign status.head       = links[0].entry;
  assign status.full       = links[vcwr_pkg::WAITER_SLOTS-1].valid;

endmodule

/* rtl/vcwr_checker.sv */
// port-level checks for the waiter release core, bound to the top level
module vcwr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input vcwr_pkg::req_t               req,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input vcwr_pkg::rsp_t               rsp,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [vcwr_pkg::PADDR_W-1:0] paddr,
  input logic [63:0]                  pwdata,
  input logic [63:0]                  prdata,
  input logic                         pready
);

  // stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp item changed while stalled");

  // only notify items carry a client and nonce
  a_notify_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind != vcwr_pkg::KIND_NOTIFY) |->
      (rsp.notify_client == 64'd0) && (rsp.notify_nonce == 64'd0))
    else $error("non-notify item with client or nonce");

  // every non-notify item closes its request
  a_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind != vcwr_pkg::KIND_NOTIFY) |-> rsp.last)
    else $error("status item without last");

  // a register write is registered and then read back on the read port
  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[3] |=> prdata == $past(pwdata))
    else $error("register readback mismatch");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind versioned_condition_waiter_release_core vcwr_checker u_vcwr_checker (.*);
